>>> design/sbcc_pkg.sv
// Shared types, widths and codes for the segment/box clearance checker.
package sbcc_pkg;

  localparam int COORD_W     = 24;
  localparam int AXIS_W      = 16;
  localparam int INSET_W     = 16;
  localparam int MODE_W      = 2;
  localparam int COUNT_OUT_W = 6;
  localparam int FRAC_BITS   = 14;

  localparam int DIFF_W  = COORD_W + 1;         // point minus centre
  localparam int PROD_W  = DIFF_W + AXIS_W;     // one projection term
  localparam int SUM_W   = PROD_W + 1;          // two terms summed
  localparam int LOC_W   = SUM_W - FRAC_BITS;   // local coordinate after floor shift
  localparam int HALF_W  = COORD_W + 1;         // half extent minus inset
  localparam int EDGE_W  = LOC_W + 1;           // slab numerators and denominators
  localparam int CROSS_W = 2 * EDGE_W;

  localparam int DEF_MAX_BOXES = 32;
  localparam logic [INSET_W-1:0] INSET_RESET = 16'd8;

  typedef enum logic [1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_APPEND  = 2'd1,
    MODE_SEGMENT = 2'd2,
    MODE_POINT   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] hx;
    logic signed [COORD_W-1:0] hy;
    logic signed [AXIS_W-1:0]  ax_x;
    logic signed [AXIS_W-1:0]  ax_y;
    logic signed [AXIS_W-1:0]  ay_x;
    logic signed [AXIS_W-1:0]  ay_y;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  typedef struct packed {
    logic capture;  // load test operands, arm the clear flag
    logic issue;    // a table read was issued this cycle
  } dp_cmd_t;

  typedef struct packed {
    logic pending;  // boxes still in the pipeline
    logic clear;    // no hit seen so far
  } dp_stat_t;

endpackage

>>> design/sbcc_ram.sv
// Generic single write port RAM with registered read.
module sbcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/sbcc_ctrl.sv
// Controller: box count, table walk sequencing and result registers.
module sbcc_ctrl #(
  parameter int MAX_BOXES = sbcc_pkg::DEF_MAX_BOXES,
  localparam int CW = $clog2(MAX_BOXES + 1),
  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [sbcc_pkg::MODE_W-1:0]        mode,
  output logic                               busy,
  output logic                               done,
  output logic                               is_clear,
  output logic                               status,
  output logic [sbcc_pkg::COUNT_OUT_W-1:0]   box_count,
  output logic                               ram_we,
  output logic [AW-1:0]                      ram_waddr,
  output logic [AW-1:0]                      ram_raddr,
  output sbcc_pkg::dp_cmd_t                  cmd,
  input  sbcc_pkg::dp_stat_t                 stat
);

  sbcc_pkg::state_t state, state_next;
  sbcc_pkg::mode_t  mode_c;
  logic [CW-1:0]    count;
  logic [CW-1:0]    idx;
  logic             clear_flag;
  logic             drop_flag;
  logic             accept;
  logic             is_test;
  logic             full;
  logic             last_issue;

  assign mode_c     = sbcc_pkg::mode_t'(mode);
  assign accept     = start && (state == sbcc_pkg::ST_IDLE);
  assign is_test    = (mode_c == sbcc_pkg::MODE_SEGMENT) || (mode_c == sbcc_pkg::MODE_POINT);
  assign full       = (count == CW'(MAX_BOXES));
  assign last_issue = (idx == count - CW'(1));

  always_comb begin
    state_next = state;
    case (state)
      sbcc_pkg::ST_IDLE: begin
        if (accept && is_test && (count != '0)) begin
          state_next = sbcc_pkg::ST_WALK;
        end
      end
      sbcc_pkg::ST_WALK: begin
        if (last_issue) begin
          state_next = sbcc_pkg::ST_DRAIN;
        end
      end
      sbcc_pkg::ST_DRAIN: begin
        if (!stat.pending) begin
          state_next = sbcc_pkg::ST_IDLE;
        end
      end
      default: state_next = sbcc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = (state != sbcc_pkg::ST_IDLE);
    cmd.capture = accept && is_test;
    cmd.issue   = (state == sbcc_pkg::ST_WALK);
    ram_we      = accept && (mode_c == sbcc_pkg::MODE_APPEND) && !full;
    ram_waddr   = count[AW-1:0];
    ram_raddr   = idx[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sbcc_pkg::ST_IDLE;
      count      <= '0;
      idx        <= '0;
      done       <= 1'b0;
      clear_flag <= 1'b0;
      drop_flag  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (accept) begin
        idx <= '0;
        case (mode_c)
          sbcc_pkg::MODE_CLEAR: begin
            count      <= '0;
            done       <= 1'b1;
            clear_flag <= 1'b0;
            drop_flag  <= 1'b0;
          end
          sbcc_pkg::MODE_APPEND: begin
            if (!full) begin
              count <= count + CW'(1);
            end
            done       <= 1'b1;
            clear_flag <= 1'b0;
            drop_flag  <= full;
          end
          default: begin
            // empty table: clear without a walk
            if (count == '0) begin
              done       <= 1'b1;
              clear_flag <= 1'b1;
              drop_flag  <= 1'b0;
            end
          end
        endcase
      end
      if (state == sbcc_pkg::ST_WALK) begin
        idx <= idx + CW'(1);
      end
      if ((state == sbcc_pkg::ST_DRAIN) && !stat.pending) begin
        done       <= 1'b1;
        clear_flag <= stat.clear;
        drop_flag  <= 1'b0;
      end
    end
  end

  assign is_clear  = clear_flag;
  assign status    = drop_flag;
  assign box_count = sbcc_pkg::COUNT_OUT_W'(count);

endmodule

>>> design/sbcc_dpath.sv
// Datapath: inset register, test operands and the per-box hit pipeline.
module sbcc_dpath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 inset_we,
  input  logic [sbcc_pkg::INSET_W-1:0]         inset_data,
  input  logic [sbcc_pkg::MODE_W-1:0]          mode,
  input  logic signed [sbcc_pkg::COORD_W-1:0]  point_a_x,
  input  logic signed [sbcc_pkg::COORD_W-1:0]  point_a_y,
  input  logic signed [sbcc_pkg::COORD_W-1:0]  point_b_x,
  input  logic signed [sbcc_pkg::COORD_W-1:0]  point_b_y,
  input  sbcc_pkg::box_t                       rbox,
  input  sbcc_pkg::dp_cmd_t                    cmd,
  output sbcc_pkg::dp_stat_t                   stat
);

  localparam int DIFF_W  = sbcc_pkg::DIFF_W;
  localparam int PROD_W  = sbcc_pkg::PROD_W;
  localparam int SUM_W   = sbcc_pkg::SUM_W;
  localparam int LOC_W   = sbcc_pkg::LOC_W;
  localparam int HALF_W  = sbcc_pkg::HALF_W;
  localparam int EDGE_W  = sbcc_pkg::EDGE_W;
  localparam int CROSS_W = sbcc_pkg::CROSS_W;
  localparam int AXIS_W  = sbcc_pkg::AXIS_W;
  localparam int FRAC    = sbcc_pkg::FRAC_BITS;

  logic [sbcc_pkg::INSET_W-1:0]        inset;
  logic signed [sbcc_pkg::COORD_W-1:0] sa_x, sa_y, sb_x, sb_y;
  logic                                seg;
  logic                                acc;
  logic [5:0]                          vld;

  // stage A: differences and inner extents
  logic signed [DIFF_W-1:0] ds_x, ds_y, de_x, de_y;
  logic signed [HALF_W-1:0] h1_x, h1_y;
  logic signed [AXIS_W-1:0] ax_x, ax_y, ay_x, ay_y;
  // stage B: projection terms
  logic signed [PROD_W-1:0] ps_xx, ps_xy, ps_yx, ps_yy;
  logic signed [PROD_W-1:0] pe_xx, pe_xy, pe_yx, pe_yy;
  logic signed [HALF_W-1:0] h2_x, h2_y;
  // stage C: local coordinates
  logic signed [SUM_W-1:0]  sum_sx, sum_sy, sum_ex, sum_ey;
  logic signed [LOC_W-1:0]  ls_x, ls_y, le_x, le_y;
  logic signed [HALF_W-1:0] h3_x, h3_y;
  // stage D: slab bounds
  logic signed [EDGE_W-1:0] en_x, ex_x, den_x, en_y, ex_y, den_y;
  logic                     z_x, z_y, in_x, in_y, p_hit4;
  logic signed [EDGE_W-1:0] c_en_x, c_ex_x, c_den_x, c_en_y, c_ex_y, c_den_y;
  logic                     c_z_x, c_z_y, c_in_x, c_in_y, c_phit;
  // stage E: cross products and per-axis checks
  logic signed [CROSS_W-1:0] cr1, cr2, cr3, cr4;
  logic                      ok_x, ok_y, any_zero, p_hit5;
  logic                      seg_hit, hit;

  always_comb begin
    sum_sx = SUM_W'(ps_xx) + SUM_W'(ps_xy);
    sum_sy = SUM_W'(ps_yx) + SUM_W'(ps_yy);
    sum_ex = SUM_W'(pe_xx) + SUM_W'(pe_xy);
    sum_ey = SUM_W'(pe_yx) + SUM_W'(pe_yy);
  end

  // slab bounds on each axis; denominator made positive
  always_comb begin
    logic signed [EDGE_W-1:0] o, d, h, hn, lx, ly, px, py;
    o  = EDGE_W'(ls_x);
    hn = (h3_x < 0) ? '0 : EDGE_W'(h3_x);
    d  = EDGE_W'(le_x) - o;
    c_z_x  = (d == '0);
    c_in_x = (o > -hn) && (o < hn);
    if (d > 0) begin
      c_en_x = -hn - o; c_ex_x = hn - o; c_den_x = d;
    end else begin
      c_en_x = o - hn;  c_ex_x = o + hn; c_den_x = -d;
    end
    o  = EDGE_W'(ls_y);
    h  = (h3_y < 0) ? '0 : EDGE_W'(h3_y);
    d  = EDGE_W'(le_y) - o;
    c_z_y  = (d == '0);
    c_in_y = (o > -h) && (o < h);
    if (d > 0) begin
      c_en_y = -h - o; c_ex_y = h - o; c_den_y = d;
    end else begin
      c_en_y = o - h;  c_ex_y = o + h; c_den_y = -d;
    end
    // point test uses unfloored extents
    lx = EDGE_W'(ls_x);
    ly = EDGE_W'(ls_y);
    px = (lx < 0) ? -lx : lx;
    py = (ly < 0) ? -ly : ly;
    c_phit = (px < EDGE_W'(h3_x)) && (py < EDGE_W'(h3_y));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inset <= sbcc_pkg::INSET_RESET;
      vld   <= '0;
      acc   <= 1'b1;
    end else begin
      if (inset_we) begin
        inset <= inset_data;
      end
      vld <= {vld[4:0], cmd.issue};
      if (cmd.capture) begin
        acc <= 1'b1;
      end else if (vld[5] && hit) begin
        acc <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sa_x <= point_a_x;
      sa_y <= point_a_y;
      sb_x <= point_b_x;
      sb_y <= point_b_y;
      seg  <= (sbcc_pkg::mode_t'(mode) == sbcc_pkg::MODE_SEGMENT);
    end
    // A
    ds_x <= DIFF_W'(sa_x) - DIFF_W'(rbox.cx);
    ds_y <= DIFF_W'(sa_y) - DIFF_W'(rbox.cy);
    de_x <= DIFF_W'(sb_x) - DIFF_W'(rbox.cx);
    de_y <= DIFF_W'(sb_y) - DIFF_W'(rbox.cy);
    h1_x <= HALF_W'(rbox.hx) - $signed({1'b0, inset});
    h1_y <= HALF_W'(rbox.hy) - $signed({1'b0, inset});
    ax_x <= rbox.ax_x;
    ax_y <= rbox.ax_y;
    ay_x <= rbox.ay_x;
    ay_y <= rbox.ay_y;
    // B
    ps_xx <= ds_x * ax_x;
    ps_xy <= ds_y * ax_y;
    ps_yx <= ds_x * ay_x;
    ps_yy <= ds_y * ay_y;
    pe_xx <= de_x * ax_x;
    pe_xy <= de_y * ax_y;
    pe_yx <= de_x * ay_x;
    pe_yy <= de_y * ay_y;
    h2_x  <= h1_x;
    h2_y  <= h1_y;
    // C: arithmetic shift keeps the floor
    ls_x <= sum_sx[SUM_W-1:FRAC];
    ls_y <= sum_sy[SUM_W-1:FRAC];
    le_x <= sum_ex[SUM_W-1:FRAC];
    le_y <= sum_ey[SUM_W-1:FRAC];
    h3_x <= h2_x;
    h3_y <= h2_y;
    // D
    en_x   <= c_en_x;
    ex_x   <= c_ex_x;
    den_x  <= c_den_x;
    en_y   <= c_en_y;
    ex_y   <= c_ex_y;
    den_y  <= c_den_y;
    z_x    <= c_z_x;
    z_y    <= c_z_y;
    in_x   <= c_in_x;
    in_y   <= c_in_y;
    p_hit4 <= c_phit;
    // E: entry on one axis against exit on the other
    cr1      <= en_x * den_y;
    cr2      <= ex_y * den_x;
    cr3      <= en_y * den_x;
    cr4      <= ex_x * den_y;
    ok_x     <= z_x ? in_x : ((ex_x >= 0) && (en_x <= den_x));
    ok_y     <= z_y ? in_y : ((ex_y >= 0) && (en_y <= den_y));
    any_zero <= z_x || z_y;
    p_hit5   <= p_hit4;
  end

  assign seg_hit = ok_x && ok_y && (any_zero || ((cr1 <= cr2) && (cr3 <= cr4)));
  assign hit     = seg ? seg_hit : p_hit5;

  assign stat.pending = |vld;
  assign stat.clear   = acc;

endmodule

>>> design/segment_box_clearance_check.sv
// Top level: segment and point clearance checks against a table of oriented boxes.
//
//   channel   signals                                   transfer when
//   item in   start, busy, mode, point_*, *_axis_*      start && !busy
//   result    done, is_clear, status, box_count         done (one cycle)
//   config    inset_we, inset_data                      inset_we
//
// Clear, append and a test on an empty table give their result the cycle after the
// transfer. A test walks the box table one entry per cycle through a five-stage hit
// pipeline behind the registered table read; its result follows once the pipeline
// has drained. busy is high for the walk and drain. Reset clears the box count and
// sets inset to 8; table contents are not cleared. Results cannot be stalled: each
// is shown for exactly one cycle.
module segment_box_clearance_check #(
  parameter int MAX_BOXES = sbcc_pkg::DEF_MAX_BOXES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [sbcc_pkg::MODE_W-1:0]          mode,
  input  logic signed [sbcc_pkg::COORD_W-1:0]  point_a_x,
  input  logic signed [sbcc_pkg::COORD_W-1:0]  point_a_y,
  input  logic signed [sbcc_pkg::COORD_W-1:0]  point_b_x,
  input  logic signed [sbcc_pkg::COORD_W-1:0]  point_b_y,
  input  logic signed [sbcc_pkg::AXIS_W-1:0]   first_axis_x,
  input  logic signed [sbcc_pkg::AXIS_W-1:0]   first_axis_y,
  input  logic signed [sbcc_pkg::AXIS_W-1:0]   second_axis_x,
  input  logic signed [sbcc_pkg::AXIS_W-1:0]   second_axis_y,
  output logic                                 done,
  output logic                                 is_clear,
  output logic                                 status,
  output logic [sbcc_pkg::COUNT_OUT_W-1:0]     box_count,
  input  logic                                 inset_we,
  input  logic [sbcc_pkg::INSET_W-1:0]         inset_data
);

  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

  sbcc_pkg::dp_cmd_t  cmd;
  sbcc_pkg::dp_stat_t stat;
  sbcc_pkg::box_t     wbox;
  sbcc_pkg::box_t     rbox;
  logic [sbcc_pkg::BOX_W-1:0] rdata;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;

  always_comb begin
    wbox.cx   = point_a_x;
    wbox.cy   = point_a_y;
    wbox.hx   = point_b_x;
    wbox.hy   = point_b_y;
    wbox.ax_x = first_axis_x;
    wbox.ax_y = first_axis_y;
    wbox.ay_x = second_axis_x;
    wbox.ay_y = second_axis_y;
  end

  assign rbox = sbcc_pkg::box_t'(rdata);

  sbcc_ram #(
    .WIDTH (sbcc_pkg::BOX_W),
    .DEPTH (MAX_BOXES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wbox),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  sbcc_ctrl #(
    .MAX_BOXES (MAX_BOXES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .mode      (mode),
    .busy      (busy),
    .done      (done),
    .is_clear  (is_clear),
    .status    (status),
    .box_count (box_count),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_raddr (ram_raddr),
    .cmd       (cmd),
    .stat      (stat)
  );

  sbcc_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .inset_we   (inset_we),
    .inset_data (inset_data),
    .mode       (mode),
    .point_a_x  (point_a_x),
    .point_a_y  (point_a_y),
    .point_b_x  (point_b_x),
    .point_b_y  (point_b_y),
    .rbox       (rbox),
    .cmd        (cmd),
    .stat       (stat)
  );

  // results only leave an idle controller
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobed while busy");

  // a walk only starts from a transfer
  a_busy_start: assert property (@(posedge clk) disable iff (rst) $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  // a dropped append leaves a full table
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
      (done && status) |-> (box_count == sbcc_pkg::COUNT_OUT_W'(MAX_BOXES)))
    else $error("drop flagged with table not full");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the segment/box clearance checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = sbcc_pkg::DEF_MAX_BOXES;
  localparam int COORD_BITS  = sbcc_pkg::COORD_W;
  localparam int AXIS_BITS   = sbcc_pkg::AXIS_W;

  typedef struct {
    longint cx, cy, hx, hy, ax_x, ax_y, ay_x, ay_y;
  } obb_t;

  typedef struct {
    sbcc_pkg::mode_t mode;
    logic signed [sbcc_pkg::COORD_W-1:0] ax, ay, bx, by;
    logic signed [sbcc_pkg::AXIS_W-1:0]  fx, fy, sx, sy;
  } op_t;

  typedef struct {
    logic clr;
    logic drop;
    logic [sbcc_pkg::COUNT_OUT_W-1:0] cnt;
  } verdict_t;

  class clearance_board;
    obb_t boxes[TABLE_DEPTH];
    int unsigned held;
    longint inset_val;
    verdict_t expected_q[$];
    int unsigned failures;

    function new();
      held = 0;
      inset_val = longint'(sbcc_pkg::INSET_RESET);
      failures = 0;
    endfunction

    function void to_local(obb_t b, longint px, longint py, output longint lx,
                           output longint ly);
      longint dx, dy;
      dx = px - b.cx;
      dy = py - b.cy;
      lx = (dx * b.ax_x + dy * b.ax_y) >>> sbcc_pkg::FRAC_BITS;
      ly = (dx * b.ay_x + dy * b.ay_y) >>> sbcc_pkg::FRAC_BITS;
    endfunction

    // slab clip of one axis; t range kept as fractions with positive denominators
    function bit clip(longint o, longint d, longint h, inout longint mn, inout longint md,
                      inout longint xn, inout longint xd);
      longint en, ex, den;
      if (d == 0) return (o > -h) && (o < h);
      if (d > 0) begin
        en = -h - o; ex = h - o; den = d;
      end else begin
        en = o - h; ex = o + h; den = -d;
      end
      if (en * md > mn * den) begin
        mn = en; md = den;
      end
      if (ex * xd < xn * den) begin
        xn = ex; xd = den;
      end
      return mn * xd <= xn * md;
    endfunction

    function bit seg_hit(obb_t b, longint sx, longint sy, longint ex, longint ey);
      longint lsx, lsy, lex, ley, hx, hy;
      longint mn, md, xn, xd;
      mn = 0; md = 1; xn = 1; xd = 1;
      to_local(b, sx, sy, lsx, lsy);
      to_local(b, ex, ey, lex, ley);
      hx = b.hx - inset_val; if (hx < 0) hx = 0;
      hy = b.hy - inset_val; if (hy < 0) hy = 0;
      if (!clip(lsx, lex - lsx, hx, mn, md, xn, xd)) return 0;
      if (!clip(lsy, ley - lsy, hy, mn, md, xn, xd)) return 0;
      return (xn >= 0) && (mn <= md);
    endfunction

    function bit pt_hit(obb_t b, longint px, longint py);
      longint lx, ly;
      to_local(b, px, py, lx, ly);
      if (lx < 0) lx = -lx;
      if (ly < 0) ly = -ly;
      return (lx < b.hx - inset_val) && (ly < b.hy - inset_val);
    endfunction

    function void note(op_t op);
      verdict_t v;
      v.clr = 1'b0;
      v.drop = 1'b0;
      case (op.mode)
        sbcc_pkg::MODE_CLEAR: held = 0;
        sbcc_pkg::MODE_APPEND: begin
          if (held >= TABLE_DEPTH) v.drop = 1'b1;
          else begin
            boxes[held] = '{op.ax, op.ay, op.bx, op.by, op.fx, op.fy, op.sx, op.sy};
            held++;
          end
        end
        default: begin
          v.clr = 1'b1;
          for (int i = 0; i < held; i++) begin
            if (op.mode == sbcc_pkg::MODE_SEGMENT ?
                seg_hit(boxes[i], op.ax, op.ay, op.bx, op.by) :
                pt_hit(boxes[i], op.ax, op.ay)) begin
              v.clr = 1'b0;
              break;
            end
          end
        end
      endcase
      v.cnt = held[sbcc_pkg::COUNT_OUT_W-1:0];
      expected_q.push_back(v);
    endfunction

    function void check(logic clr, logic drop, logic [sbcc_pkg::COUNT_OUT_W-1:0] cnt);
      verdict_t v;
      if (expected_q.size() == 0) begin
        $error("unexpected result: is_clear %0b status %0b box_count %0d", clr, drop, cnt);
        failures++;
        return;
      end
      v = expected_q.pop_front();
      if (clr !== v.clr) begin
        $error("is_clear: expected %0b, got %0b", v.clr, clr); failures++;
      end
      if (drop !== v.drop) begin
        $error("status: expected %0b, got %0b", v.drop, drop); failures++;
      end
      if (cnt !== v.cnt) begin
        $error("box_count: expected %0d, got %0d", v.cnt, cnt); failures++;
      end
    endfunction
  endclass

  logic clk, rst, start, busy, done, is_clear, status, inset_we;
  logic [sbcc_pkg::COUNT_OUT_W-1:0] box_count;
  logic [sbcc_pkg::INSET_W-1:0] inset_data;
  op_t cur;

  clearance_board board = new();

  segment_box_clearance_check dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(cur.mode),
    .point_a_x(cur.ax), .point_a_y(cur.ay), .point_b_x(cur.bx), .point_b_y(cur.by),
    .first_axis_x(cur.fx), .first_axis_y(cur.fy),
    .second_axis_x(cur.sx), .second_axis_y(cur.sy),
    .done(done), .is_clear(is_clear), .status(status), .box_count(box_count),
    .inset_we(inset_we), .inset_data(inset_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result check first: a result never shares an edge with its own transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (done) board.check(is_clear, status, box_count);
      if (start && !busy) board.note(cur);
    end
  end

  task automatic issue(op_t op, int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start <= 1;
    cur <= op;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic settle();
    start <= 0;
    @(posedge clk);
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_inset(logic [sbcc_pkg::INSET_W-1:0] v);
    inset_we <= 1;
    inset_data <= v;
    @(posedge clk);
    inset_we <= 0;
    board.inset_val = longint'(v);
  endtask

  function automatic op_t mk(sbcc_pkg::mode_t m, int ax, int ay, int bx, int by,
                             int fx = 16384, int fy = 0, int sx = 0, int sy = 16384);
    op_t o;
    o.mode = m;
    o.ax = COORD_BITS'(ax); o.ay = COORD_BITS'(ay);
    o.bx = COORD_BITS'(bx); o.by = COORD_BITS'(by);
    o.fx = AXIS_BITS'(fx); o.fy = AXIS_BITS'(fy);
    o.sx = AXIS_BITS'(sx); o.sy = AXIS_BITS'(sy);
    return o;
  endfunction

  function automatic int near(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // mostly boxes and probes in a small window; some pure noise
  function automatic op_t rand_op();
    op_t o;
    int r, pick;
    int ux[8] = '{16384, 11585, 0, -11585, -16384, -11585, 0, 11585};
    int uy[8] = '{0, 11585, 16384, 11585, 0, -11585, -16384, -11585};
    r = $urandom_range(99);
    if (r < 8) begin
      o.mode = sbcc_pkg::mode_t'($urandom_range(3));
      o.ax = COORD_BITS'($urandom); o.ay = COORD_BITS'($urandom);
      o.bx = COORD_BITS'($urandom); o.by = COORD_BITS'($urandom);
      o.fx = AXIS_BITS'(near(16384)); o.fy = AXIS_BITS'(near(16384));
      o.sx = AXIS_BITS'(near(16384)); o.sy = AXIS_BITS'(near(16384));
      return o;
    end
    o = mk(r < 12 ? sbcc_pkg::MODE_CLEAR : r < 45 ? sbcc_pkg::MODE_APPEND :
           r < 75 ? sbcc_pkg::MODE_SEGMENT : sbcc_pkg::MODE_POINT,
           near(3000), near(3000), near(3000), near(3000));
    if (o.mode == sbcc_pkg::MODE_APPEND) begin
      o.bx = COORD_BITS'(int'($urandom_range(1500)) - 50);
      o.by = COORD_BITS'(int'($urandom_range(1500)) - 50);
      pick = $urandom_range(7);
      if ($urandom_range(3) == 0) begin
        o.fx = AXIS_BITS'(near(16384)); o.fy = AXIS_BITS'(near(16384));
        o.sx = AXIS_BITS'(near(16384)); o.sy = AXIS_BITS'(near(16384));
      end else begin
        o.fx = AXIS_BITS'(ux[pick]); o.fy = AXIS_BITS'(uy[pick]);
        o.sx = AXIS_BITS'(-uy[pick]); o.sy = AXIS_BITS'(ux[pick]);
      end
    end else begin
      o.fx = AXIS_BITS'(near(16384)); o.fy = AXIS_BITS'(near(16384));
      o.sx = AXIS_BITS'(near(16384)); o.sy = AXIS_BITS'(near(16384));
      if ($urandom_range(4) == 0) o.by = o.ay;
      if ($urandom_range(4) == 0) o.bx = o.ax;
    end
    return o;
  endfunction

  initial begin
    int idle_of[4] = '{0, 86, 14, 0};
    logic [sbcc_pkg::INSET_W-1:0] insets[4] = '{16'd0, 16'd65535, 16'd25, 16'd8};
    rst = 1; start = 0; inset_we = 0; inset_data = '0;
    cur = mk(sbcc_pkg::MODE_CLEAR, 0, 0, 0, 0);
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty table, then boxes, tangent and zero-direction probes
    issue(mk(sbcc_pkg::MODE_SEGMENT, -8388608, 8388607, 8388607, -8388608), 0);
    issue(mk(sbcc_pkg::MODE_POINT, 0, 0, 0, 0), 0);
    issue(mk(sbcc_pkg::MODE_APPEND, 0, 0, 100, 50), 0);
    issue(mk(sbcc_pkg::MODE_APPEND, 1000, 1000, 200, 200, 11585, 11585, -11585, 11585), 0);
    issue(mk(sbcc_pkg::MODE_APPEND, -2000, 0, -30, 400, -16384, 0, 0, -16384), 0);
    issue(mk(sbcc_pkg::MODE_SEGMENT, -500, 0, 500, 0), 0);
    issue(mk(sbcc_pkg::MODE_SEGMENT, -500, 42, 500, 42), 0);
    issue(mk(sbcc_pkg::MODE_SEGMENT, -500, 60, 500, 60), 0);
    issue(mk(sbcc_pkg::MODE_SEGMENT, 50, -500, 50, 500), 0);
    issue(mk(sbcc_pkg::MODE_SEGMENT, 10, 10, 10, 10), 0);
    issue(mk(sbcc_pkg::MODE_POINT, 91, 0, 0, 0), 0);
    issue(mk(sbcc_pkg::MODE_POINT, 92, 0, 0, 0), 0);
    issue(mk(sbcc_pkg::MODE_POINT, -2000, 0, 0, 0), 0);
    issue(mk(sbcc_pkg::MODE_APPEND, 8388607, -8388608, 8388607, 8388607,
             -16384, 16384, 16384, -16384), 0);
    issue(mk(sbcc_pkg::MODE_POINT, 8388607, 8388607, 0, 0), 0);
    issue(mk(sbcc_pkg::MODE_SEGMENT, -8388608, -8388608, 8388607, 8388607), 0);
    for (int i = 0; i < 30; i++) issue(mk(sbcc_pkg::MODE_APPEND, i * 10, 0, 5, 5), 0);
    issue(mk(sbcc_pkg::MODE_POINT, 3000, 3000, 0, 0), 0);
    issue(mk(sbcc_pkg::MODE_CLEAR, 0, 0, 0, 0), 0);
    issue(mk(sbcc_pkg::MODE_POINT, 0, 0, 0, 0), 0);

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      write_inset(insets[ph]);
      for (int n = 0; n < 275; n++) issue(rand_op(), idle_of[ph]);
    end
    settle();
    repeat (50) @(posedge clk);
    if (board.failures == 0 && board.expected_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

>>> filelist.f
design/sbcc_pkg.sv
design/sbcc_ram.sv
design/sbcc_ctrl.sv
design/sbcc_dpath.sv
design/segment_box_clearance_check.sv
verif/testbench.sv
